/* rtl/core/crs_pkg.sv */
// ----------------------------------------------------------------------------
// crs_pkg
// Shared types for the streaming convolution block: request, response,
// queue command and state encodings.
// ----------------------------------------------------------------------------
package crs_pkg;

   localparam int PIX_W  = 16;
   localparam int PROD_W = 32;
   localparam int CONV_W = 36;

   typedef struct packed {
      logic                    mode;
      logic [7:0]              weight_index;
      logic signed [PIX_W-1:0] value;
   } crs_req_type;

   typedef struct packed {
      logic [CONV_W-1:0] conv_value;
      logic [2:0]        filter_number;
      logic [4:0]        out_row;
      logic [4:0]        out_col;
      logic              last;
   } crs_rsp_type;

   // One queue entry apart from the window snapshot
   typedef struct packed {
      logic                    is_window;
      logic [7:0]              widx;
      logic signed [PIX_W-1:0] value;
      logic [4:0]              orow;
      logic [4:0]              ocol;
   } crs_cmd_type;

   localparam int CMD_W = $bits(crs_cmd_type);

   typedef enum logic [1:0] {
      F_IDLE,
      F_SHIFT,
      F_PUSH
   } crs_front_state_type;

   typedef enum logic [1:0] {
      B_IDLE,
      B_WAIT,
      B_ISSUE,
      B_DRAIN
   } crs_back_state_type;

endpackage

/* rtl/core/crs_front.sv */
// ----------------------------------------------------------------------------
// crs_front
// Accepts requests, keeps line buffer, sliding window and raster position,
// and forwards weight writes and complete windows to the queue.
// ----------------------------------------------------------------------------
module crs_front
   import crs_pkg::*;
#(
   parameter int IMAGE_H  = 32,
   parameter int IMAGE_W  = 32,
   parameter int KER_ROWS = 5,
   parameter int KER_COLS = 5
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  crs_req_type                            req_data,
   output logic                                   q_push,
   output crs_cmd_type                            q_cmd,
   output logic [KER_ROWS*KER_COLS*PIX_W-1:0]     q_win,
   input  logic                                   q_full
);

   localparam int RW     = $clog2(IMAGE_H);
   localparam int CW     = $clog2(IMAGE_W);
   localparam int LROWS  = (KER_ROWS > 1) ? KER_ROWS - 1 : 1;
   localparam int LINE_W = LROWS * PIX_W;

   crs_front_state_type state_ff, state_in;

   logic [RW-1:0]            prow_ff, prow_in;
   logic [CW-1:0]            pcol_ff, pcol_in;
   logic signed [PIX_W-1:0]  pix_ff;
   logic [LINE_W-1:0]        line_mem [IMAGE_W];
   logic [LINE_W-1:0]        line_rd_ff;
   logic [LINE_W-1:0]        line_wr;
   logic signed [PIX_W-1:0]  col [KER_ROWS];
   logic signed [PIX_W-1:0]  win_ff [KER_ROWS][KER_COLS];
   logic [4:0]               orow_ff, ocol_ff;
   logic                     accept;
   logic                     shift_en;
   logic                     emit;

   assign accept   = req_valid && !req_stall;
   assign shift_en = (state_ff == F_SHIFT);
   assign emit     = (prow_ff >= RW'(KER_ROWS - 1)) && (pcol_ff >= CW'(KER_COLS - 1));

   always_comb begin
      for (int k = 0; k < KER_ROWS - 1; k++) begin
         col[k] = line_rd_ff[k*PIX_W +: PIX_W];
      end
      col[KER_ROWS-1] = pix_ff;
      line_wr = line_rd_ff;
      for (int k = 0; k < KER_ROWS - 1; k++) begin
         line_wr[k*PIX_W +: PIX_W] = col[k+1];
      end
      for (int r = 0; r < KER_ROWS; r++) begin
         for (int c = 0; c < KER_COLS; c++) begin
            q_win[(r*KER_COLS + c)*PIX_W +: PIX_W] = win_ff[r][c];
         end
      end
   end

   // Line buffer: one read and one write per pixel at the current column
   always_ff @(posedge clock) begin
      line_rd_ff <= line_mem[pcol_ff];
      if (shift_en) begin
         line_mem[pcol_ff] <= line_wr;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && req_data.mode) begin
         pix_ff <= req_data.value;
      end
      if (shift_en) begin
         for (int r = 0; r < KER_ROWS; r++) begin
            for (int c = 0; c < KER_COLS - 1; c++) begin
               win_ff[r][c] <= win_ff[r][c+1];
            end
            win_ff[r][KER_COLS-1] <= col[r];
         end
         orow_ff <= 5'(prow_ff - RW'(KER_ROWS - 1));
         ocol_ff <= 5'(pcol_ff - CW'(KER_COLS - 1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         prow_ff  <= '0;
         pcol_ff  <= '0;
      end else begin
         state_ff <= state_in;
         prow_ff  <= prow_in;
         pcol_ff  <= pcol_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      prow_in   = prow_ff;
      pcol_in   = pcol_ff;
      req_stall = 1'b1;
      q_push    = 1'b0;
      q_cmd     = '0;
      case (state_ff)
         F_IDLE: begin
            req_stall = q_full;
            q_cmd.widx  = req_data.weight_index;
            q_cmd.value = req_data.value;
            if (accept) begin
               if (req_data.mode) begin
                  state_in = F_SHIFT;
               end else begin
                  q_push = 1'b1;
               end
            end
         end
         F_SHIFT: begin
            // advance raster position, wrap at end of frame
            if (pcol_ff == CW'(IMAGE_W - 1)) begin
               pcol_in = '0;
               prow_in = (prow_ff == RW'(IMAGE_H - 1)) ? '0 : prow_ff + 1'b1;
            end else begin
               pcol_in = pcol_ff + 1'b1;
            end
            state_in = emit ? F_PUSH : F_IDLE;
         end
         F_PUSH: begin
            q_cmd.is_window = 1'b1;
            q_cmd.orow      = orow_ff;
            q_cmd.ocol      = ocol_ff;
            if (!q_full) begin
               q_push   = 1'b1;
               state_in = F_IDLE;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

endmodule

/* rtl/core/crs_queue.sv */
// ----------------------------------------------------------------------------
// crs_queue
// Two-entry FIFO between the front and the back part.
// ----------------------------------------------------------------------------
module crs_queue
   import crs_pkg::*;
#(
   parameter int DATA_W = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [DATA_W-1:0] push_data,
   output logic              full,
   input  logic              pop,
   output logic [DATA_W-1:0] pop_data,
   output logic              empty
);

   logic [DATA_W-1:0] slot_ff [2];
   logic              wptr_ff;
   logic              rptr_ff;
   logic [1:0]        count_ff;

   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign pop_data = slot_ff[rptr_ff];

   always_ff @(posedge clock) begin
      if (push && !full) begin
         slot_ff[wptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= 1'b0;
         rptr_ff  <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         if (push && !full) begin
            wptr_ff <= ~wptr_ff;
         end
         if (pop && !empty) begin
            rptr_ff <= ~rptr_ff;
         end
         count_ff <= count_ff + {1'b0, push && !full} - {1'b0, pop && !empty};
      end
   end

endmodule

/* rtl/core/crs_back.sv */
// ----------------------------------------------------------------------------
// crs_back
// Weight memory and one multiply-accumulate unit. Runs queued weight writes
// and computes one result per filter for each queued window.
// ----------------------------------------------------------------------------
module crs_back
   import crs_pkg::*;
#(
   parameter int KER_ROWS    = 5,
   parameter int KER_COLS    = 5,
   parameter int NUM_FILTERS = 6
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               q_empty,
   output logic                               q_pop,
   input  crs_cmd_type                        q_cmd,
   input  logic [KER_ROWS*KER_COLS*PIX_W-1:0] q_win,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output crs_rsp_type                        rsp_data
);

   localparam int WIN   = KER_ROWS * KER_COLS;
   localparam int WDEP  = WIN * NUM_FILTERS;
   localparam int AW    = (WDEP > 1) ? $clog2(WDEP) : 1;
   localparam int TW    = (WIN > 1) ? $clog2(WIN) : 1;
   localparam int FW    = (NUM_FILTERS > 1) ? $clog2(NUM_FILTERS) : 1;
   localparam int ACC_A = PROD_W + TW + 1;
   localparam int ACC_W = (ACC_A > CONV_W + 2) ? ACC_A : CONV_W + 2;

   crs_back_state_type state_ff, state_in;

   logic signed [PIX_W-1:0]  wmem [WDEP];
   logic signed [PIX_W-1:0]  win_ff [WIN];
   logic [4:0]               orow_ff, ocol_ff;
   logic [AW-1:0]            addr_ff;
   logic [TW-1:0]            tap_ff;
   logic [FW-1:0]            fcnt_ff;
   logic signed [PIX_W-1:0]  wq_ff, px_ff;
   logic                     v1_ff, first1_ff, last1_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic                     v2_ff, first2_ff, last2_ff;
   logic signed [ACC_W-1:0]  acc_ff, acc_sum, prod_ext;
   logic                     out_valid_ff;
   crs_rsp_type              out_ff;
   logic                     issue;
   logic                     start;
   logic                     wr_en;
   logic                     out_free;
   logic                     done;

   assign issue    = (state_ff == B_ISSUE);
   assign out_free = !out_valid_ff || !rsp_stall;
   assign done     = v2_ff && last2_ff;
   assign wr_en    = q_pop && !q_cmd.is_window && (int'(q_cmd.widx) < WDEP);
   assign start    = q_pop && q_cmd.is_window;
   assign prod_ext = ACC_W'(prod_ff);
   assign acc_sum  = first2_ff ? prod_ext : acc_ff + prod_ext;

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         wmem[AW'(q_cmd.widx)] <= q_cmd.value;
      end
      wq_ff <= wmem[addr_ff];
   end

   always_ff @(posedge clock) begin
      if (start) begin
         for (int k = 0; k < WIN; k++) begin
            win_ff[k] <= q_win[k*PIX_W +: PIX_W];
         end
         orow_ff <= q_cmd.orow;
         ocol_ff <= q_cmd.ocol;
      end
      px_ff     <= win_ff[tap_ff];
      first1_ff <= (tap_ff == '0);
      last1_ff  <= (tap_ff == TW'(WIN - 1));
      prod_ff   <= wq_ff * px_ff;
      first2_ff <= first1_ff;
      last2_ff  <= last1_ff;
      if (v2_ff) begin
         acc_ff <= acc_sum;
      end
      if (done) begin
         // clamp below at zero, saturate above the result width
         if (acc_sum[ACC_W-1]) begin
            out_ff.conv_value <= '0;
         end else if (|acc_sum[ACC_W-2:CONV_W]) begin
            out_ff.conv_value <= '1;
         end else begin
            out_ff.conv_value <= acc_sum[CONV_W-1:0];
         end
         out_ff.filter_number <= 3'(fcnt_ff);
         out_ff.out_row       <= orow_ff;
         out_ff.out_col       <= ocol_ff;
         out_ff.last          <= (fcnt_ff == FW'(NUM_FILTERS - 1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         addr_ff      <= '0;
         tap_ff       <= '0;
         fcnt_ff      <= '0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         v1_ff    <= issue;
         v2_ff    <= v1_ff;
         if (start) begin
            addr_ff <= '0;
            tap_ff  <= '0;
            fcnt_ff <= '0;
         end else if (issue) begin
            addr_ff <= addr_ff + 1'b1;
            tap_ff  <= (tap_ff == TW'(WIN - 1)) ? '0 : tap_ff + 1'b1;
         end
         if (done) begin
            fcnt_ff      <= fcnt_ff + 1'b1;
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      q_pop    = 1'b0;
      case (state_ff)
         B_IDLE: begin
            q_pop = !q_empty;
            if (!q_empty && q_cmd.is_window) begin
               state_in = B_WAIT;
            end
         end
         B_WAIT: begin
            // start a filter only once the output register will be free
            if (out_free) begin
               state_in = B_ISSUE;
            end
         end
         B_ISSUE: begin
            if (tap_ff == TW'(WIN - 1)) begin
               state_in = B_DRAIN;
            end
         end
         B_DRAIN: begin
            if (done) begin
               state_in = (fcnt_ff == FW'(NUM_FILTERS - 1)) ? B_IDLE : B_WAIT;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

endmodule

/* rtl/core/conv2d_relu_stream.sv */
// ----------------------------------------------------------------------------
// conv2d_relu_stream
// Valid-mode 2D convolution with several kernels, stride one, then ReLU.
// ----------------------------------------------------------------------------
// Usage: each request on req_ carries mode, weight_index and value. Mode 0
// writes one kernel weight (index filter*KH*KW + row*KW + col, indexes past
// the store are dropped); mode 1 delivers the next pixel in raster order.
// Load all weights before the first pixel that completes a window.
// Each pixel completing a full window gives NUM_FILTERS results on rsp_,
// in filter order, last set on the final filter.
// A weight write is pushed to the queue in the cycle it is accepted. A pixel
// passes through the shift state, and the push state too when it completes a
// window, and the front takes no new request until it is back in idle; the
// back then works through the window one filter at a time with the single
// multiply-accumulate unit reading one weight per cycle from the weight
// memory. A two-entry queue lets the front take pixels while the back works.
// Reset clears the raster position, the queue and the output valid; weight,
// line and window stores hold garbage until written.
// A stalled response holds its data; the back waits for the output register
// before starting the next filter, and the front stalls once the queue fills.
// ----------------------------------------------------------------------------
module conv2d_relu_stream
   import crs_pkg::*;
#(
   parameter int IMAGE_H     = 32,
   parameter int IMAGE_W     = 32,
   parameter int KER_ROWS    = 5,
   parameter int KER_COLS    = 5,
   parameter int NUM_FILTERS = 6
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  crs_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output crs_rsp_type rsp_data
);

   localparam int WIN_W = KER_ROWS * KER_COLS * PIX_W;
   localparam int Q_W   = CMD_W + WIN_W;

   logic              push, pop, full, empty;
   crs_cmd_type       f_cmd, b_cmd;
   logic [WIN_W-1:0]  f_win, b_win;
   logic [Q_W-1:0]    q_out;

   assign b_cmd = q_out[CMD_W-1:0];
   assign b_win = q_out[Q_W-1:CMD_W];

   crs_front #(
      .IMAGE_H  (IMAGE_H),
      .IMAGE_W  (IMAGE_W),
      .KER_ROWS (KER_ROWS),
      .KER_COLS (KER_COLS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_push    (push),
      .q_cmd     (f_cmd),
      .q_win     (f_win),
      .q_full    (full)
   );

   crs_queue #(
      .DATA_W (Q_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data ({f_win, f_cmd}),
      .full      (full),
      .pop       (pop),
      .pop_data  (q_out),
      .empty     (empty)
   );

   crs_back #(
      .KER_ROWS    (KER_ROWS),
      .KER_COLS    (KER_COLS),
      .NUM_FILTERS (NUM_FILTERS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (empty),
      .q_pop     (pop),
      .q_cmd     (b_cmd),
      .q_win     (b_win),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

/* rtl/core/crs_checker.sv */
// ----------------------------------------------------------------------------
// crs_checker
// Port-level checks on the response channel of conv2d_relu_stream.
// ----------------------------------------------------------------------------
module crs_checker
   import crs_pkg::*;
#(
   parameter int NUM_FILTERS = 6
) (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input crs_rsp_type rsp_data
);

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   a_last_filter: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.last |->
         (NUM_FILTERS > 8) || (rsp_data.filter_number == 3'(NUM_FILTERS - 1)))
      else $error("last set on a filter other than the final one");

endmodule

bind conv2d_relu_stream crs_checker #(.NUM_FILTERS(NUM_FILTERS)) u_crs_checker (.*);
